@@ rtl/core/bba_pkg.sv @@
// bba_pkg: shared types and constants of the buddy block allocator
// node status codes, datapath command and status structs
// no dependencies
`timescale 1ns / 1ps

package bba_pkg;

	localparam int MIN_ORDER_DEF   = 8;
	localparam int TREE_LEVELS_DEF = 10;

	// node status codes as kept in the tree memory
	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_SPLIT = 2'd1,
		ST_USED  = 2'd2
	} node_st_t;

	// tree memory address source
	typedef enum logic [2:0] {
		AS_NODE,
		AS_LEFT,
		AS_RIGHT,
		AS_PARENT
	} asel_t;

	// move of the tree cursor
	typedef enum logic [2:0] {
		MV_NONE,
		MV_ROOT,
		MV_LEFT,
		MV_RIGHT,
		MV_SIB,
		MV_UP,
		MV_INC
	} mv_t;

	typedef struct packed {
		logic     mem_rd;
		logic     mem_wr;
		node_st_t wdata;
		asel_t    asel;
		mv_t      mv;
		logic     load;
		logic     off_ld;
		logic     j_inc;
		logic     wasf_set;
		logic     left_ld;
		logic     freed_ld;
		logic     total_sub;
		logic     total_add;
		logic     ok_set;
		logic     res_ld;
	} dp_cmd_t;

	typedef struct packed {
		node_st_t st;
		logic     fit;
		logic     j_last;
		logic     at_target;
		logic     is_root;
		logic     is_leaf;
		logic     side_par;
		logic     wasf_par;
		logic     side_cur;
		logic     free_ok;
		logic     mismatch;
		logic     left_free;
		logic     clr_last;
	} dp_stat_t;

endpackage

@@ rtl/core/bba_in_if.sv @@
// bba_in_if: request channel of the buddy block allocator
// depends on nothing
`timescale 1ns / 1ps

interface bba_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] request_size;
	logic [31:0] address;

	modport source (output valid, kind, request_size, address, input ready);
	modport sink (input valid, kind, request_size, address, output ready);
endinterface

@@ rtl/core/bba_out_if.sv @@
// bba_out_if: result channel of the buddy block allocator
// depends on nothing
`timescale 1ns / 1ps

interface bba_out_if;
	logic        valid;
	logic        ready;
	logic        alloc_ok;
	logic [31:0] block_address;
	logic [17:0] freed_bytes;
	logic [17:0] free_total;

	modport source (output valid, alloc_ok, block_address, freed_bytes, free_total,
		input ready);
	modport sink (input valid, alloc_ok, block_address, freed_bytes, free_total,
		output ready);
endinterface

@@ rtl/core/bba_datapath.sv @@
// bba_datapath: tree memory, tree cursor, size search, byte counters, result word
// depends on bba_pkg
`timescale 1ns / 1ps

module bba_datapath #(
	parameter int MIN_ORDER   = bba_pkg::MIN_ORDER_DEF,
	parameter int TREE_LEVELS = bba_pkg::TREE_LEVELS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bba_pkg::dp_cmd_t cmd,
	output bba_pkg::dp_stat_t stat,
	input  logic [31:0]      base,
	input  logic [31:0]      request_size,
	input  logic [31:0]      address,
	output logic             res_ok,
	output logic [31:0]      res_blk,
	output logic [17:0]      res_freed,
	output logic [17:0]      res_total
);

	localparam int RW    = MIN_ORDER + TREE_LEVELS - 1;
	localparam int NODES = (1 << TREE_LEVELS) - 1;
	localparam int NW    = TREE_LEVELS;
	localparam int DW    = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
	localparam logic [17:0] TOTAL_RST = 18'((33'd1 << RW));

	logic [1:0]             mem [NODES];
	bba_pkg::node_st_t      rdata_q;
	logic [31:0]            req_q;
	logic [31:0]            addr_q;
	logic [NW-1:0]          node_q;
	logic [DW-1:0]          depth_q;
	logic [DW-1:0]          j_q;
	logic [TREE_LEVELS-1:0] path_q;
	logic [TREE_LEVELS-1:0] wasf_q;
	logic                   left_free_q;
	logic [17:0]            freed_q;
	logic [17:0]            total_q;
	logic                   ok_q;

	logic [DW:0]            sh_cur;
	logic [NW-1:0]          pw_cur;
	logic [NW-1:0]          pw_child;
	logic [NW-1:0]          left_a;
	logic [NW-1:0]          right_a;
	logic [NW-1:0]          sib_a;
	logic [NW-1:0]          parent_a;
	logic [NW-1:0]          maddr;
	logic [DW-1:0]          dm1;
	logic [RW-1:0]          off;
	logic [32:0]            diff;
	logic [TREE_LEVELS-1:0] lowmask;
	logic [17:0]            want18;
	logic [17:0]            chunk18;

	// cursor neighbors
	always_comb begin
		sh_cur   = (DW+1)'(TREE_LEVELS) - {1'b0, depth_q};
		pw_cur   = NW'(1) << sh_cur;
		pw_child = NW'(1) << (sh_cur - (DW+1)'(1));
		dm1      = depth_q - DW'(1);
		left_a   = node_q + NW'(1);
		right_a  = node_q + pw_child;
		sib_a    = node_q - NW'(1) + pw_cur;
		parent_a = path_q[dm1] ? (node_q - pw_cur) : (node_q - NW'(1));
	end

	// path bits to region offset, current and deeper levels below
	always_comb begin
		off = '0;
		for (int i = 0; i < TREE_LEVELS; i++) begin
			off[RW-1-i] = path_q[i];
		end
		for (int i = 0; i < TREE_LEVELS; i++) begin
			lowmask[i] = ((DW+1)'(i) >= {1'b0, depth_q});
		end
	end

	// free address check and sizes
	always_comb begin
		diff    = {1'b0, addr_q} - {1'b0, base};
		want18  = 18'((33'd1 << (6'(MIN_ORDER) + 6'(j_q))));
		chunk18 = 18'((33'd1 << (6'(RW) - 6'(depth_q))));
	end

	always_comb begin
		case (cmd.asel)
			bba_pkg::AS_LEFT:   maddr = left_a;
			bba_pkg::AS_RIGHT:  maddr = right_a;
			bba_pkg::AS_PARENT: maddr = parent_a;
			default:            maddr = node_q;
		endcase
	end

	// status to the controller
	always_comb begin
		stat.st        = rdata_q;
		stat.fit       = ({1'b0, req_q} <= (33'd1 << (6'(MIN_ORDER) + 6'(j_q))));
		stat.j_last    = (j_q == DW'(TREE_LEVELS - 1));
		stat.at_target = (({1'b0, depth_q} + {1'b0, j_q}) == (DW+1)'(TREE_LEVELS - 1));
		stat.is_root   = (depth_q == '0);
		stat.is_leaf   = (depth_q == DW'(TREE_LEVELS - 1));
		stat.side_par  = path_q[dm1];
		stat.wasf_par  = wasf_q[dm1];
		stat.side_cur  = path_q[depth_q];
		stat.free_ok   = !diff[32] && ((diff[31:0] >> RW) == 32'd0)
			&& (diff[MIN_ORDER-1:0] == '0);
		stat.mismatch  = |(path_q & lowmask);
		stat.left_free = left_free_q;
		stat.clr_last  = (node_q == NW'(NODES - 1));
	end

	// tree memory, one port, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[maddr] <= cmd.wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= bba_pkg::node_st_t'(mem[maddr]);
		end
	end

	// cursor and free total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q  <= '0;
			depth_q <= '0;
			path_q  <= '0;
			total_q <= TOTAL_RST;
		end else begin
			if (cmd.load) begin
				path_q <= '0;
			end
			if (cmd.off_ld) begin
				for (int i = 0; i < TREE_LEVELS; i++) begin
					path_q[i] <= diff[RW-1-i];
				end
			end
			case (cmd.mv)
				bba_pkg::MV_ROOT: begin
					node_q  <= '0;
					depth_q <= '0;
				end
				bba_pkg::MV_LEFT: begin
					node_q  <= left_a;
					depth_q <= depth_q + DW'(1);
				end
				bba_pkg::MV_RIGHT: begin
					node_q          <= right_a;
					path_q[depth_q] <= 1'b1;
					depth_q         <= depth_q + DW'(1);
				end
				bba_pkg::MV_SIB: begin
					node_q      <= sib_a;
					path_q[dm1] <= 1'b1;
				end
				bba_pkg::MV_UP: begin
					node_q      <= parent_a;
					path_q[dm1] <= 1'b0;
					depth_q     <= dm1;
				end
				bba_pkg::MV_INC: begin
					node_q <= node_q + NW'(1);
				end
				default: ;
			endcase
			if (cmd.total_sub) begin
				total_q <= total_q - want18;
			end else if (cmd.total_add) begin
				total_q <= total_q + freed_q;
			end
		end
	end

	// operation scratch and result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= request_size;
			addr_q  <= address;
			j_q     <= '0;
			freed_q <= '0;
			ok_q    <= 1'b0;
		end
		if (cmd.j_inc) begin
			j_q <= j_q + DW'(1);
		end
		if (cmd.wasf_set) begin
			wasf_q[depth_q] <= (rdata_q == bba_pkg::ST_FREE);
		end
		if (cmd.left_ld) begin
			left_free_q <= (rdata_q == bba_pkg::ST_FREE);
		end
		if (cmd.freed_ld) begin
			freed_q <= (rdata_q == bba_pkg::ST_USED) ? chunk18 : 18'd0;
		end
		if (cmd.ok_set) begin
			ok_q <= 1'b1;
		end
		if (cmd.res_ld) begin
			res_ok    <= ok_q;
			res_blk   <= ok_q ? (base + 32'(off)) : 32'd0;
			res_freed <= freed_q;
			res_total <= total_q;
		end
	end

endmodule

@@ rtl/core/bba_ctrl.sv @@
// bba_ctrl: sequencer of the buddy block allocator (clearing, search, free walk)
// depends on bba_pkg
`timescale 1ns / 1ps

module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_kind,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bba_pkg::dp_stat_t stat,
	output bba_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SIZE,
		S_ARD,
		S_AEV,
		S_ARET,
		S_FCHK,
		S_FRD,
		S_FEV,
		S_FUP,
		S_FRDL,
		S_FRDR,
		S_FMRG,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.mem_wr = 1'b1;
				cmd.wdata  = bba_pkg::ST_FREE;
				cmd.asel   = bba_pkg::AS_NODE;
				cmd.mv     = bba_pkg::MV_INC;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = in_kind ? S_FCHK : S_SIZE;
				end
			end
			// round request up, one power of two a cycle
			S_SIZE: begin
				if (stat.fit) begin
					cmd.mv  = bba_pkg::MV_ROOT;
					state_d = S_ARD;
				end else if (stat.j_last) begin
					state_d = S_DONE;
				end else begin
					cmd.j_inc = 1'b1;
				end
			end
			S_ARD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_AEV;
			end
			// visit one node of the depth-first search
			S_AEV: begin
				if (stat.st == bba_pkg::ST_USED) begin
					state_d = S_ARET;
				end else if (stat.at_target) begin
					if (stat.st == bba_pkg::ST_SPLIT) begin
						state_d = S_ARET;
					end else begin
						cmd.mem_wr    = 1'b1;
						cmd.wdata     = bba_pkg::ST_USED;
						cmd.total_sub = 1'b1;
						cmd.ok_set    = 1'b1;
						state_d       = S_DONE;
					end
				end else begin
					cmd.wasf_set = 1'b1;
					cmd.mem_wr   = 1'b1;
					cmd.wdata    = bba_pkg::ST_SPLIT;
					cmd.mv       = bba_pkg::MV_LEFT;
					state_d      = S_ARD;
				end
			end
			// failed subtree: try right sibling or back out, restoring new splits
			S_ARET: begin
				if (stat.is_root) begin
					state_d = S_DONE;
				end else if (!stat.side_par) begin
					cmd.mv  = bba_pkg::MV_SIB;
					state_d = S_ARD;
				end else begin
					if (stat.wasf_par) begin
						cmd.mem_wr = 1'b1;
						cmd.wdata  = bba_pkg::ST_FREE;
						cmd.asel   = bba_pkg::AS_PARENT;
					end
					cmd.mv = bba_pkg::MV_UP;
				end
			end
			S_FCHK: begin
				if (stat.free_ok) begin
					cmd.off_ld = 1'b1;
					cmd.mv     = bba_pkg::MV_ROOT;
					state_d    = S_FRD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FRD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_FEV;
			end
			// walk down toward the block at the offset
			S_FEV: begin
				if (stat.st != bba_pkg::ST_SPLIT) begin
					if (!stat.mismatch) begin
						cmd.mem_wr   = 1'b1;
						cmd.wdata    = bba_pkg::ST_FREE;
						cmd.freed_ld = 1'b1;
					end
					state_d = S_FUP;
				end else if (stat.is_leaf) begin
					state_d = S_FUP;
				end else begin
					cmd.mv  = stat.side_cur ? bba_pkg::MV_RIGHT : bba_pkg::MV_LEFT;
					state_d = S_FRD;
				end
			end
			S_FUP: begin
				if (stat.is_root) begin
					cmd.total_add = 1'b1;
					state_d       = S_DONE;
				end else begin
					cmd.mv  = bba_pkg::MV_UP;
					state_d = S_FRDL;
				end
			end
			S_FRDL: begin
				cmd.mem_rd = 1'b1;
				cmd.asel   = bba_pkg::AS_LEFT;
				state_d    = S_FRDR;
			end
			S_FRDR: begin
				cmd.left_ld = 1'b1;
				cmd.mem_rd  = 1'b1;
				cmd.asel    = bba_pkg::AS_RIGHT;
				state_d     = S_FMRG;
			end
			// merge parent when both halves are free
			S_FMRG: begin
				if (stat.left_free && (stat.st == bba_pkg::ST_FREE)) begin
					cmd.mem_wr = 1'b1;
					cmd.wdata  = bba_pkg::ST_FREE;
				end
				state_d = S_FUP;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_SIZE || state_q == S_FCHK))
		else $error("accepted word did not start an operation");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!cmd.mem_wr && !cmd.mem_rd))
		else $error("tree memory access while idle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result word raised outside completion");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("input taken during clearing pass");

endmodule

@@ rtl/core/buddy_block_allocator_core.sv @@
// buddy_block_allocator_core: top level, APB region base register and channels
// depends on bba_pkg, bba_in_if, bba_out_if, bba_ctrl, bba_datapath
// sequence: alloc sizes the request, then reads and evaluates each node visited
//   and steps back out of a failed subtree; free checks the address, reads down one
//   level at a time, then per level up reads both halves and merges them if free
// throughput: one word at a time, set by the single-port tree memory walk
// reset: clearing pass marks every tree node free before the first word is taken
`timescale 1ns / 1ps

module buddy_block_allocator_core #(
	parameter int MIN_ORDER   = bba_pkg::MIN_ORDER_DEF,
	parameter int TREE_LEVELS = bba_pkg::TREE_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bba_in_if.sink      in_word,
	bba_out_if.source   out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_REGION_BASE = 1'b0;

	logic [31:0]       base_q;
	bba_pkg::dp_cmd_t  cmd;
	bba_pkg::dp_stat_t stat;

	// region base register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_REGION_BASE) ? base_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_REGION_BASE)) begin
			base_q <= pwdata;
		end
	end

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_word.valid),
		.in_kind   (in_word.kind),
		.in_ready  (in_word.ready),
		.out_valid (out_word.valid),
		.out_ready (out_word.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bba_datapath #(
		.MIN_ORDER   (MIN_ORDER),
		.TREE_LEVELS (TREE_LEVELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.base         (base_q),
		.request_size (in_word.request_size),
		.address      (in_word.address),
		.res_ok       (out_word.alloc_ok),
		.res_blk      (out_word.block_address),
		.res_freed    (out_word.freed_bytes),
		.res_total    (out_word.free_total)
	);

endmodule
